// File: sv/rhi_pkg.sv
// rhi_pkg: widths, register indexes and beat structs for the 4D ray / hypersphere
// intersection pipeline. No dependencies; used by every module of the block.
package rhi_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COORD_W    = 32;
	localparam int DIR_W      = FRAC_BITS + 2;
	localparam int RAD_W      = COORD_W - 1;
	localparam int RSQ_W      = 2 * COORD_W - 2;
	localparam int MIND_W     = FRAC_BITS;

	// internal datapath widths
	localparam int CD_W       = COORD_W + 1;            // center - origin, signed
	localparam int PROD_W     = CD_W + DIR_W;           // |cd| * |dir|
	localparam int DOT_W      = PROD_W + 3;             // signed sum of four products
	localparam int BM_W       = PROD_W + 2 - FRAC_BITS; // |b|
	localparam int SQ_W       = 2 * CD_W + 2;           // |cd|^2 summed
	localparam int DISC_W     = 2 * BM_W + 2;           // discriminant, even width
	localparam int RT_W       = DISC_W / 2;             // square root
	localparam int T_W        = RT_W + 2;               // signed hit distance
	localparam int OFFP_W     = T_W - 1 + DIR_W;        // t * |dir|
	localparam int OFF_W      = OFFP_W - FRAC_BITS;
	localparam int PT_W       = OFF_W + 2;              // unsaturated point, signed
	localparam int DIFF_W     = PT_W + 1;               // point - center, signed
	localparam int DIV_LAT    = FRAC_BITS + 1;          // normal divider depth

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = RSQ_W;

	localparam int IN_RAW_W   = 5 * COORD_W + 4 * DIR_W;
	localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W  = RAD_W + 4 * COORD_W + 4 * DIR_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X,
		CFG_CENTER_Y,
		CFG_CENTER_Z,
		CFG_CENTER_W,
		CFG_RADIUS,
		CFG_RADIUS_SQ,
		CFG_MIN_DIST
	} cfg_idx_t;

	typedef struct packed {
		logic [3:0][COORD_W-1:0] org;
		logic [3:0][DIR_W-1:0]   dir;
		logic [COORD_W-1:0]      prior;
		logic                    shadow;
	} ray_t;

	typedef struct packed {
		ray_t            ray;
		logic            bneg;
		logic [BM_W-1:0] bmag;
		logic            miss;
	} sq_sb_t;

	typedef struct packed {
		logic                    hit;
		logic                    full;
		logic [RAD_W-1:0]        tdist;
		logic [3:0][COORD_W-1:0] pt;
	} res_t;

endpackage

// File: sv/rhi_sqrt.sv
// rhi_sqrt: pipelined integer square root, one result bit per stage, with a
// sideband beat carried alongside. Depends on rhi_pkg.
module rhi_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_vld,
	input  logic [rhi_pkg::DISC_W-1:0]  in_rad,
	input  rhi_pkg::sq_sb_t             in_sb,
	output logic                        out_vld,
	output logic [rhi_pkg::RT_W-1:0]    out_root,
	output rhi_pkg::sq_sb_t             out_sb
);
	localparam int DW    = rhi_pkg::DISC_W;
	localparam int RW    = rhi_pkg::RT_W;
	localparam int REM_W = RW + 3;

	logic [REM_W-1:0]  rem_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [DW-1:0]     x_s    [RW];
	rhi_pkg::sq_sb_t   sb_s   [RW];
	logic [RW-1:0]     vld_s;

	logic [REM_W-1:0]  rem_c  [RW];
	logic [RW-1:0]     root_c [RW];
	logic [DW-1:0]     x_c    [RW];
	logic [REM_W-1:0]  rem_n  [RW];
	logic [RW-1:0]     root_n [RW];

	always_comb begin
		logic [REM_W-1:0] cat;
		logic [REM_W-1:0] trial;
		rem_c[0]  = '0;
		root_c[0] = '0;
		x_c[0]    = in_rad;
		for (int k = 1; k < RW; k++) begin
			rem_c[k]  = rem_s[k-1];
			root_c[k] = root_s[k-1];
			x_c[k]    = x_s[k-1];
		end
		for (int k = 0; k < RW; k++) begin
			cat   = {rem_c[k][REM_W-3:0], x_c[k][DW-1 -: 2]};
			trial = REM_W'({root_c[k], 2'b01});
			if (cat >= trial) begin
				rem_n[k]  = cat - trial;
				root_n[k] = {root_c[k][RW-2:0], 1'b1};
			end else begin
				rem_n[k]  = cat;
				root_n[k] = {root_c[k][RW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[RW-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < RW; k++) begin
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
				x_s[k]    <= x_c[k] << 2;
			end
			sb_s[0] <= in_sb;
			for (int k = 1; k < RW; k++) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	assign out_vld  = vld_s[RW-1];
	assign out_root = root_s[RW-1];
	assign out_sb   = sb_s[RW-1];
endmodule

// File: sv/rhi_div.sv
// rhi_div: one normal component, (point - center) / radius in Q1.FRAC_BITS,
// truncated and clamped to +-1.0; restoring divider, one quotient bit per stage.
// Depends on rhi_pkg.
module rhi_div (
	input  logic                              clk,
	input  logic                              adv,
	input  logic signed [rhi_pkg::DIFF_W-1:0] diff,
	input  logic [rhi_pkg::RAD_W-1:0]         radius,
	output logic signed [rhi_pkg::DIR_W-1:0]  quot
);
	localparam int FB  = rhi_pkg::FRAC_BITS;
	localparam int DFW = rhi_pkg::DIFF_W;
	localparam int R_W = rhi_pkg::RAD_W + 1;
	localparam int QW  = FB + 1;
	localparam int DRW = rhi_pkg::DIR_W;

	logic [DFW-1:0] mag;
	logic           full_c;

	logic [R_W-1:0] r_s    [FB+1];
	logic [QW-1:0]  q_s    [FB+1];
	logic           neg_s  [FB+1];
	logic           full_s [FB+1];

	logic [R_W-1:0] r_n [FB+1];
	logic [QW-1:0]  q_n [FB+1];

	always_comb begin
		logic [R_W-1:0] r2;
		mag    = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
		full_c = (mag >= DFW'(radius)) && (mag != '0);
		r_n[0] = full_c ? '0 : R_W'(mag);
		q_n[0] = '0;
		for (int k = 1; k <= FB; k++) begin
			r2 = {r_s[k-1][R_W-2:0], 1'b0};
			// zero remainder never sets a bit (zero difference with zero radius)
			if (r2 >= R_W'(radius) && r2 != '0) begin
				r_n[k] = r2 - R_W'(radius);
				q_n[k] = {q_s[k-1][QW-2:0], 1'b1};
			end else begin
				r_n[k] = r2;
				q_n[k] = {q_s[k-1][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k <= FB; k++) begin
				r_s[k] <= r_n[k];
				q_s[k] <= q_n[k];
			end
			neg_s[0]  <= diff[DFW-1];
			full_s[0] <= full_c;
			for (int k = 1; k <= FB; k++) begin
				neg_s[k]  <= neg_s[k-1];
				full_s[k] <= full_s[k-1];
			end
		end
	end

	always_comb begin
		logic signed [DRW-1:0] m;
		m    = full_s[FB] ? DRW'(QW'(1) << FB) : DRW'(q_s[FB]);
		quot = neg_s[FB] ? -m : m;
	end
endmodule

// File: sv/ray_hypersphere_intersect_top.sv
// ray_hypersphere_intersect_top: 4D ray against a configured hypersphere, fully
// pipelined. Depends on rhi_pkg, rhi_sqrt and rhi_div.
//
// Usage
//   Sphere center, radius, radius squared and the minimum accepted distance sit
//   in registers written through cfg_we / cfg_addr / cfg_wdata (one write per
//   cycle, no read-back); write them only while no ray is in flight.
//   Rays enter as s_* beats; each gives exactly one m_* result beat, in order.
//   m_tuser is the hit flag; distance, point and normal are zero on a miss and
//   on a shadow-only hit.
// Timing
//   One beat per cycle sustained while m_tready stays high. The path is 7 front
//   stages (difference, dot products, sums, |b|, b^2 partials, add,
//   discriminant) + RT_W square root stages + 3 stages (pick t, t*dir,
//   point) + FRAC_BITS+1 divider stages + the output register. The square
//   root, one bit a stage, sets the depth.
// Reset and stall
//   arst_n clears all valid bits and loads the register reset values. The whole
//   pipe moves as one: when m_tready is low while a result is held, every stage
//   holds and s_tready drops, so nothing is dropped or duplicated. Empty stages
//   still fill in that case only once the output frees.
module ray_hypersphere_intersect_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rhi_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [rhi_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// origin_x, origin_y, origin_z, origin_w, direction_x..direction_w, prior_distance
	input  logic [rhi_pkg::IN_DATA_W-1:0]     s_tdata,
	// shadow_only
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// distance, point_x..point_w, normal_x..normal_w, zero pad
	output logic [rhi_pkg::OUT_DATA_W-1:0]    m_tdata,
	// hit
	output logic                              m_tuser
);
	localparam int FB   = rhi_pkg::FRAC_BITS;
	localparam int CW   = rhi_pkg::COORD_W;
	localparam int DRW  = rhi_pkg::DIR_W;
	localparam int RDW  = rhi_pkg::RAD_W;
	localparam int RSW  = rhi_pkg::RSQ_W;
	localparam int MDW  = rhi_pkg::MIND_W;
	localparam int CDW  = rhi_pkg::CD_W;
	localparam int PW   = rhi_pkg::PROD_W;
	localparam int DTW  = rhi_pkg::DOT_W;
	localparam int BMW  = rhi_pkg::BM_W;
	localparam int SQW  = rhi_pkg::SQ_W;
	localparam int DSW  = rhi_pkg::DISC_W;
	localparam int RTW  = rhi_pkg::RT_W;
	localparam int TW   = rhi_pkg::T_W;
	localparam int OPW  = rhi_pkg::OFFP_W;
	localparam int OFW  = rhi_pkg::OFF_W;
	localparam int PTW  = rhi_pkg::PT_W;
	localparam int DFW  = rhi_pkg::DIFF_W;
	localparam int DL   = rhi_pkg::DIV_LAT;
	localparam int ODW  = rhi_pkg::OUT_DATA_W;
	localparam int LO_W = (BMW + 1) / 2;
	localparam int HI_W = BMW - LO_W;

	// point saturation bounds, signed coordinate range
	localparam logic signed [PTW-1:0] PT_MAX = {{(PTW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [PTW-1:0] PT_MIN = {{(PTW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	// ---------------- configuration registers ----------------
	logic signed [CW-1:0] ctr_q [4];
	logic [RDW-1:0]       radius_q;
	logic [RSW-1:0]       rsq_q;
	logic [MDW-1:0]       mind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) ctr_q[i] <= '0;
			radius_q <= RDW'(1) << FB;
			rsq_q    <= RSW'(1) << (2 * FB);
			mind_q   <= MDW'(1);
		end else if (cfg_we) begin
			unique case (rhi_pkg::cfg_idx_t'(cfg_addr))
				rhi_pkg::CFG_CENTER_X:  ctr_q[0] <= cfg_wdata[CW-1:0];
				rhi_pkg::CFG_CENTER_Y:  ctr_q[1] <= cfg_wdata[CW-1:0];
				rhi_pkg::CFG_CENTER_Z:  ctr_q[2] <= cfg_wdata[CW-1:0];
				rhi_pkg::CFG_CENTER_W:  ctr_q[3] <= cfg_wdata[CW-1:0];
				rhi_pkg::CFG_RADIUS:    radius_q <= cfg_wdata[RDW-1:0];
				rhi_pkg::CFG_RADIUS_SQ: rsq_q    <= cfg_wdata[RSW-1:0];
				rhi_pkg::CFG_MIN_DIST:  mind_q   <= cfg_wdata[MDW-1:0];
				default: ;
			endcase
		end
	end

	// whole pipe advances together
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	rhi_pkg::ray_t ray_in;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ray_in.org[i] = s_tdata[i*CW +: CW];
			ray_in.dir[i] = s_tdata[4*CW + i*DRW +: DRW];
		end
		ray_in.prior  = s_tdata[4*CW + 4*DRW +: CW];
		ray_in.shadow = s_tuser;
	end

	// valid bits of the front and back stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic sq_vld;
	logic [DL-1:0] v_ln;

	// ---------------- s1: center - origin ----------------
	rhi_pkg::ray_t          ray_s1, ray_s2, ray_s3, ray_s4, ray_s5, ray_s6, ray_s7;
	logic signed [CDW-1:0]  cd_s1 [4];

	// ---------------- s2: products ----------------
	logic signed [DTW-1:0]  term_s2 [4];
	logic [2*CDW-1:0]       sq_s2   [4];
	logic signed [DTW-1:0]  term_c  [4];
	logic [2*CDW-1:0]       sq_c    [4];

	always_comb begin
		logic [CDW-1:0]        cm;
		logic [DRW-1:0]        dm;
		logic [PW-1:0]         pp;
		logic signed [DTW-1:0] pe;
		for (int i = 0; i < 4; i++) begin
			cm = cd_s1[i][CDW-1] ? CDW'(-cd_s1[i]) : CDW'(cd_s1[i]);
			dm = ray_s1.dir[i][DRW-1] ? DRW'(-ray_s1.dir[i]) : ray_s1.dir[i];
			pp = cm * dm;
			pe = DTW'(pp);
			term_c[i] = (cd_s1[i][CDW-1] != ray_s1.dir[i][DRW-1]) ? -pe : pe;
			sq_c[i]   = cm * cm;
		end
	end

	// ---------------- s3: sums ----------------
	logic signed [DTW-1:0] dot_s3;
	logic [SQW-1:0]        csq_s3, csq_s4, csq_s5, csq_s6;

	// ---------------- s4: |b| ----------------
	logic [BMW-1:0] bmag_s4, bmag_s5, bmag_s6, bmag_s7;
	logic           bneg_s4, bneg_s5, bneg_s6, bneg_s7;
	logic [DTW-1:0] adot_c;
	assign adot_c = dot_s3[DTW-1] ? DTW'(-dot_s3) : DTW'(dot_s3);

	// ---------------- s5: b^2 partials ----------------
	logic [2*LO_W-1:0]      pll_s5;
	logic [LO_W+HI_W-1:0]   plh_s5;
	logic [2*HI_W-1:0]      phh_s5;

	// ---------------- s6: b^2 + r^2 ----------------
	logic [DSW-1:0] lhs_s6;

	// ---------------- s7: discriminant ----------------
	logic [DSW-1:0] disc_s7;
	logic           miss_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (adv) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{s_tvalid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s1 <= ray_in;
			for (int i = 0; i < 4; i++) begin
				cd_s1[i] <= CDW'(ctr_q[i]) - CDW'($signed(ray_in.org[i]));
			end
			ray_s2 <= ray_s1;
			for (int i = 0; i < 4; i++) begin
				term_s2[i] <= term_c[i];
				sq_s2[i]   <= sq_c[i];
			end
			ray_s3 <= ray_s2;
			dot_s3 <= term_s2[0] + term_s2[1] + term_s2[2] + term_s2[3];
			csq_s3 <= SQW'(sq_s2[0]) + SQW'(sq_s2[1]) + SQW'(sq_s2[2]) + SQW'(sq_s2[3]);
			ray_s4  <= ray_s3;
			csq_s4  <= csq_s3;
			bmag_s4 <= adot_c[FB +: BMW];
			bneg_s4 <= dot_s3[DTW-1];
			ray_s5  <= ray_s4;
			csq_s5  <= csq_s4;
			bmag_s5 <= bmag_s4;
			bneg_s5 <= bneg_s4;
			pll_s5  <= bmag_s4[LO_W-1:0] * bmag_s4[LO_W-1:0];
			plh_s5  <= bmag_s4[LO_W-1:0] * bmag_s4[BMW-1:LO_W];
			phh_s5  <= bmag_s4[BMW-1:LO_W] * bmag_s4[BMW-1:LO_W];
			ray_s6  <= ray_s5;
			csq_s6  <= csq_s5;
			bmag_s6 <= bmag_s5;
			bneg_s6 <= bneg_s5;
			lhs_s6  <= (DSW'(phh_s5) << (2 * LO_W)) + (DSW'(plh_s5) << (LO_W + 1))
				+ DSW'(pll_s5) + DSW'(rsq_q);
			ray_s7  <= ray_s6;
			bmag_s7 <= bmag_s6;
			bneg_s7 <= bneg_s6;
			disc_s7 <= lhs_s6 - DSW'(csq_s6);
			miss_s7 <= lhs_s6 < DSW'(csq_s6);
		end
	end

	// ---------------- square root ----------------
	rhi_pkg::sq_sb_t sb_in, sb_out;
	logic [RTW-1:0]  root;
	assign sb_in = '{ray: ray_s7, bneg: bneg_s7, bmag: bmag_s7, miss: miss_s7};

	rhi_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (v_s7),
		.in_rad   (disc_s7),
		.in_sb    (sb_in),
		.out_vld  (sq_vld),
		.out_root (root),
		.out_sb   (sb_out)
	);

	// ---------------- s8: pick nearer positive root, accept test ----------------
	logic signed [TW-1:0] t_c;
	logic                 hit_c, full_c;
	always_comb begin
		logic signed [TW-1:0] b, rt, t1, t2, pr;
		logic                 rej;
		b   = sb_out.bneg ? -TW'(sb_out.bmag) : TW'(sb_out.bmag);
		rt  = TW'(root);
		t1  = b + rt;
		t2  = b - rt;
		t_c = (t1 < 0 || (t2 > 0 && t2 < t1)) ? t2 : t1;
		pr  = TW'($signed(sb_out.ray.prior));
		rej = (pr > 0) && (t_c < TW'(mind_q) || t_c > pr);
		hit_c  = !sb_out.miss && (t_c > 0) && (sb_out.ray.shadow || !rej);
		full_c = hit_c && !sb_out.ray.shadow;
	end

	logic [TW-2:0]           t_s8;
	logic                    hit_s8, full_s8, hit_s9, full_s9;
	logic [3:0][CW-1:0]      org_s8, org_s9;
	logic [3:0][DRW-1:0]     dir_s8;
	logic [OPW-1:0]          prod_s9 [4];
	logic [3:0]              dneg_s9;
	logic [RDW-1:0]          dist_s9;

	// ---------------- s10: point and point - center ----------------
	logic signed [DFW-1:0]   diff_s10 [4];
	rhi_pkg::res_t           res_s10;
	logic signed [DFW-1:0]   diff_c   [4];
	logic [3:0][CW-1:0]      pts_c;

	always_comb begin
		logic [OFW-1:0]        off;
		logic signed [PTW-1:0] pt, so;
		for (int i = 0; i < 4; i++) begin
			off = prod_s9[i][FB +: OFW];
			so  = PTW'(off);
			pt  = PTW'($signed(org_s9[i])) + (dneg_s9[i] ? -so : so);
			diff_c[i] = DFW'(pt) - DFW'(ctr_q[i]);
			if (pt > PT_MAX)
				pts_c[i] = {1'b0, {(CW-1){1'b1}}};
			else if (pt < PT_MIN)
				pts_c[i] = {1'b1, {(CW-1){1'b0}}};
			else
				pts_c[i] = pt[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s8, v_s9, v_s10} <= '0;
			v_ln <= '0;
		end else if (adv) begin
			{v_s8, v_s9, v_s10} <= {sq_vld, v_s8, v_s9};
			v_ln <= {v_ln[DL-2:0], v_s10};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s8    <= t_c[TW-2:0];
			hit_s8  <= hit_c;
			full_s8 <= full_c;
			org_s8  <= sb_out.ray.org;
			dir_s8  <= sb_out.ray.dir;

			hit_s9  <= hit_s8;
			full_s9 <= full_s8;
			org_s9  <= org_s8;
			for (int i = 0; i < 4; i++) begin
				prod_s9[i] <= t_s8 * (dir_s8[i][DRW-1] ? DRW'(-dir_s8[i]) : dir_s8[i]);
				dneg_s9[i] <= dir_s8[i][DRW-1];
			end
			dist_s9 <= (t_s8 > (TW-1)'({RDW{1'b1}})) ? {RDW{1'b1}} : t_s8[RDW-1:0];

			for (int i = 0; i < 4; i++) diff_s10[i] <= diff_c[i];
			res_s10.hit   <= hit_s9;
			res_s10.full  <= full_s9;
			res_s10.tdist <= dist_s9;
			res_s10.pt    <= pts_c;
		end
	end

	// ---------------- normal: four divider lanes ----------------
	logic signed [DRW-1:0] nrm [4];
	for (genvar g = 0; g < 4; g++) begin : g_div
		rhi_div u_div (
			.clk    (clk),
			.adv    (adv),
			.diff   (diff_s10[g]),
			.radius (radius_q),
			.quot   (nrm[g])
		);
	end

	// result fields ride beside the divider
	rhi_pkg::res_t res_ln [DL];
	always_ff @(posedge clk) begin
		if (adv) begin
			res_ln[0] <= res_s10;
			for (int k = 1; k < DL; k++) res_ln[k] <= res_ln[k-1];
		end
	end

	// ---------------- output register ----------------
	logic [ODW-1:0] pack_c;
	always_comb begin
		pack_c = '0;
		pack_c[RDW-1:0] = res_ln[DL-1].tdist;
		for (int i = 0; i < 4; i++) begin
			pack_c[RDW + i*CW +: CW]          = res_ln[DL-1].pt[i];
			pack_c[RDW + 4*CW + i*DRW +: DRW] = nrm[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= v_ln[DL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tuser <= res_ln[DL-1].hit;
			m_tdata <= res_ln[DL-1].full ? pack_c : '0;
		end
	end
endmodule

// File: dv/ray_hypersphere_intersect_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for ray_hypersphere_intersect_top: streams 4D rays, predicts
// each hit / distance / point / normal in fixed point. Depends on rhi_pkg.
module ray_hypersphere_intersect_top_test;

	localparam int LIMIT_CYCLES = 400000;
	localparam int LAT = 70;

	typedef struct {
		logic [rhi_pkg::IN_DATA_W-1:0] data;
		logic                          shadow;
	} ray_beat_t;

	typedef struct {
		logic                           hit;
		logic [rhi_pkg::OUT_DATA_W-1:0] data;
	} hit_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rhi_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
	logic [rhi_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [rhi_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [rhi_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;

	ray_hypersphere_intersect_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sphere registers as the predictor sees them
	logic signed [31:0] sph_center [4];
	logic [30:0] sph_radius;
	logic [61:0] sph_rsq;
	logic [15:0] sph_mind;

	ray_beat_t ray_queue[$];
	hit_beat_t hit_queue[$];
	int n_errors = 0;
	int n_hits = 0, n_shadow_hits = 0, n_results = 0;
	int cycles = 0;
	bit hold_off = 1'b0;

	task automatic report_mismatch(input string what, input logic [127:0] got,
			input logic [127:0] want);
		n_errors++;
		$display("MISMATCH beat %0d %s: got %h want %h", n_results, what, got, want);
	endtask

	// integer floor square root of a non-negative value
	function automatic logic [127:0] isqrt(input logic [127:0] v);
		logic [127:0] r, c;
		r = 0;
		for (int k = 63; k >= 0; k--) begin
			c = r | (128'd1 << k);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic logic signed [17:0] normal_of(input logic signed [127:0] diff);
		logic [127:0] m, q, r;
		m = diff < 0 ? -diff : diff;
		q = 0;
		if (m == 0)
			return 18'sd0;
		if (m >= sph_radius)
			q = 128'd65536;
		else begin
			r = m;
			for (int i = 0; i < 16; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= sph_radius) begin
					r = r - sph_radius;
					q[0] = 1'b1;
				end
			end
		end
		return diff < 0 ? -q[17:0] : q[17:0];
	endfunction

	// Expected result of one ray against the current sphere.
	function automatic hit_beat_t intersect_ray(input ray_beat_t rb);
		hit_beat_t hb;
		logic signed [127:0] org [4], dir [4], cd [4], dot, csq, b, bmag, lhs, root;
		logic signed [127:0] t, t2, prior, off, pt, satpt, q;
		logic [30:0] dist_v;
		int sum_pos;
		hb.hit = 1'b0;
		hb.data = '0;
		dot = 0;
		csq = 0;
		for (int i = 0; i < 4; i++) begin
			org[i] = $signed(rb.data[32*i +: 32]);
			dir[i] = $signed(rb.data[128 + 18*i +: 18]);
			cd[i] = sph_center[i] - org[i];
			dot = dot + cd[i] * dir[i];
			csq = csq + cd[i] * cd[i];
		end
		prior = $signed(rb.data[200 +: 32]);
		// b truncates toward zero
		bmag = (dot < 0 ? -dot : dot) >>> 16;
		b = dot < 0 ? -bmag : bmag;
		lhs = bmag * bmag + sph_rsq;
		if (lhs < csq)
			return hb;
		root = isqrt(lhs - csq);
		t = b + root;
		t2 = b - root;
		if (t < 0 || (t2 > 0 && t2 < t))
			t = t2;
		if (t <= 0)
			return hb;
		if (rb.shadow) begin
			hb.hit = 1'b1;
			return hb;
		end
		if (prior > 0 && (t < sph_mind || t > prior))
			return hb;
		hb.hit = 1'b1;
		dist_v = t > 128'sh7FFFFFFF ? 31'h7FFFFFFF : t[30:0];
		hb.data[30:0] = dist_v;
		for (int i = 0; i < 4; i++) begin
			off = (t * (dir[i] < 0 ? -dir[i] : dir[i])) >>> 16;
			pt = org[i] + (dir[i] < 0 ? -off : off);
			satpt = pt > 128'sh7FFFFFFF ? 128'sh7FFFFFFF :
				(pt < -128'sh80000000 ? -128'sh80000000 : pt);
			hb.data[31 + 32*i +: 32] = satpt[31:0];
			hb.data[159 + 18*i +: 18] = normal_of(pt - sph_center[i]);
		end
		return hb;
	endfunction

	// Driver: one pending ray at a time, random gap before each.
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				hit_queue.push_back(intersect_ray(ray_queue.pop_front()));
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
				if ($urandom_range(0, 4) == 0) gap = 0;
			end
			if (gap > 0) begin
				gap--;
				s_tvalid <= 1'b0;
			end else if (ray_queue.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= ray_queue[0].data;
				s_tuser <= ray_queue[0].shadow;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Monitor: random stall per result, plus the long hold-off window.
	int stall = 0;
	hit_beat_t exp_b;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (hit_queue.size() == 0) begin
					report_mismatch("unexpected result beat", m_tdata, '0);
				end else begin
					exp_b = hit_queue.pop_front();
					if (m_tuser !== exp_b.hit)
						report_mismatch("hit", m_tuser, exp_b.hit);
					if (m_tdata[30:0] !== exp_b.data[30:0])
						report_mismatch("distance", m_tdata[30:0], exp_b.data[30:0]);
					for (int i = 0; i < 4; i++) begin
						if (m_tdata[31 + 32*i +: 32] !== exp_b.data[31 + 32*i +: 32])
							report_mismatch($sformatf("point[%0d]", i),
								m_tdata[31 + 32*i +: 32], exp_b.data[31 + 32*i +: 32]);
						if (m_tdata[159 + 18*i +: 18] !== exp_b.data[159 + 18*i +: 18])
							report_mismatch($sformatf("normal[%0d]", i),
								m_tdata[159 + 18*i +: 18], exp_b.data[159 + 18*i +: 18]);
					end
					if (exp_b.hit) n_hits++;
					n_results++;
				end
				stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
			end
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, hit_queue.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(input rhi_pkg::cfg_idx_t idx,
			input logic [rhi_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rhi_pkg::CFG_CENTER_X: sph_center[0] = val[31:0];
			rhi_pkg::CFG_CENTER_Y: sph_center[1] = val[31:0];
			rhi_pkg::CFG_CENTER_Z: sph_center[2] = val[31:0];
			rhi_pkg::CFG_CENTER_W: sph_center[3] = val[31:0];
			rhi_pkg::CFG_RADIUS: sph_radius = val[30:0];
			rhi_pkg::CFG_RADIUS_SQ: sph_rsq = val[61:0];
			rhi_pkg::CFG_MIN_DIST: sph_mind = val[15:0];
			default: ;
		endcase
	endtask

	// load a sphere; radius squared is written as given, not derived from r
	task automatic load_sphere(input logic signed [31:0] cx, cy, cz, cw,
			input logic [30:0] r, input logic [61:0] rsq, input logic [15:0] mind);
		write_reg(rhi_pkg::CFG_CENTER_X, {{30{cx[31]}}, cx});
		write_reg(rhi_pkg::CFG_CENTER_Y, {{30{cy[31]}}, cy});
		write_reg(rhi_pkg::CFG_CENTER_Z, {{30{cz[31]}}, cz});
		write_reg(rhi_pkg::CFG_CENTER_W, {{30{cw[31]}}, cw});
		write_reg(rhi_pkg::CFG_RADIUS, r);
		write_reg(rhi_pkg::CFG_RADIUS_SQ, rsq);
		write_reg(rhi_pkg::CFG_MIN_DIST, mind);
	endtask

	task automatic wait_drained();
		while (ray_queue.size() > 0 || hit_queue.size() > 0)
			@(posedge clk);
		repeat (LAT) @(posedge clk);
	endtask

	task automatic push_ray(input logic signed [31:0] o [4], input logic signed [17:0] d [4],
			input logic signed [31:0] prior, input logic shadow);
		ray_beat_t rb;
		rb.data = '0;
		for (int i = 0; i < 4; i++) begin
			rb.data[32*i +: 32] = o[i];
			rb.data[128 + 18*i +: 18] = d[i];
		end
		rb.data[200 +: 32] = prior;
		rb.shadow = shadow;
		if (shadow) n_shadow_hits++;
		ray_queue.push_back(rb);
	endtask

	// Random ray: mostly aimed near the sphere with a unit axis-ish direction.
	task automatic push_random_ray();
		logic signed [31:0] o [4];
		logic signed [17:0] d [4];
		logic signed [31:0] prior;
		int ax, mode;
		mode = $urandom_range(0, 9);
		ax = $urandom_range(0, 3);
		for (int i = 0; i < 4; i++) begin
			if (mode == 0)
				o[i] = $urandom;
			else
				o[i] = sph_center[i] + $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
			d[i] = '0;
		end
		if (mode < 2) begin
			for (int i = 0; i < 4; i++)
				d[i] = $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
		end else if (mode < 5) begin
			// diagonal unit direction, components +-0.5
			for (int i = 0; i < 4; i++)
				d[i] = $urandom_range(0, 1) ? 18'sd32768 : -18'sd32768;
		end else begin
			d[ax] = $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
			// place origin behind the sphere along the axis so it is often hit
			o[ax] = sph_center[ax] - (d[ax] > 0 ? 1 : -1) * $signed($urandom_range(0, 8 * 65536));
		end
		case ($urandom_range(0, 3))
			0: prior = 0;
			1: prior = -$signed($urandom_range(0, 1000));
			2: prior = $urandom_range(1, 16 * 65536);
			default: prior = $urandom;
		endcase
		push_ray(o, d, prior, $urandom_range(0, 5) == 0);
	endtask

	initial begin
		logic signed [31:0] o [4];
		logic signed [17:0] d [4];
		sph_center = '{0, 0, 0, 0};
		sph_radius = 31'd65536;
		sph_rsq = 62'h1_0000_0000;
		sph_mind = 16'd1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset sphere (unit radius at origin).
		o = '{-3 * 65536, 0, 0, 0};
		d = '{18'sd65536, 0, 0, 0};
		push_ray(o, d, 0, 1'b0);                    // straight hit, t = 2
		push_ray(o, d, 0, 1'b1);                    // shadow-only hit
		push_ray(o, d, 65536, 1'b0);                // prior closer: miss
		push_ray(o, d, 4 * 65536, 1'b0);            // prior farther: hit
		o = '{0, 0, 0, 0};
		push_ray(o, d, 0, 1'b0);                    // origin inside, far root
		o = '{3 * 65536, 0, 0, 0};
		push_ray(o, d, 0, 1'b0);                    // sphere behind ray
		o = '{-3 * 65536, 5 * 65536, 0, 0};
		push_ray(o, d, 0, 1'b0);                    // negative discriminant
		o = '{-3 * 65536, 65536, 0, 0};
		push_ray(o, d, 0, 1'b0);                    // grazing, zero root
		o = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
		d = '{-18'sd65536, 18'sd65536, -18'sd65536, 18'sd65536};
		push_ray(o, d, 32'sh7FFFFFFF, 1'b0);        // field extremes
		d = '{18'sd65536, -18'sd65536, 18'sd65536, -18'sd65536};
		push_ray(o, d, 32'sh80000000, 1'b1);
		o = '{0, -2 * 65536, 0, 0};
		d = '{0, 0, 0, 18'sd65536};
		push_ray(o, d, 0, 1'b0);
		d = '{18'sd32768, 18'sd32768, 18'sd32768, 18'sd32768};
		o = '{-2 * 65536, -2 * 65536, -2 * 65536, -2 * 65536};
		push_ray(o, d, 0, 1'b0);
		push_ray(o, d, 2 * 65536, 1'b0);            // prior just around t
		wait_drained();

		// Huge radius, large min distance; these rays miss (negative discriminant).
		load_sphere(32'sh7FFFFFFF, 32'sh80000000, 0, 0, 31'h7FFFFFFF,
			62'h3FFF_FFFF_FFFF_FFFF, 16'hFFFF);
		o = '{32'sh80000000, 32'sh7FFFFFFF, 0, 0};
		d = '{18'sd65536, 0, 0, 0};
		push_ray(o, d, 0, 1'b0);
		push_ray(o, d, 100, 1'b0);                  // prior below min distance
		d = '{-18'sd65536, 0, 0, 0};
		push_ray(o, d, 0, 1'b0);
		wait_drained();

		// Zero radius squared / tiny radius: the hit point is the center, so normals are zero.
		load_sphere(65536, -65536, 0, 0, 31'd1, 62'd0, 16'd0);
		o = '{-65536, -65536, 0, 0};
		d = '{18'sd65536, 0, 0, 0};
		push_ray(o, d, 0, 1'b0);
		push_ray(o, d, 1, 1'b0);
		wait_drained();

		// Random phases over several spheres; long receiver hold-off in the first.
		for (int ph = 0; ph < 4; ph++) begin
			logic [30:0] r;
			r = ph == 3 ? 31'd1 : 31'($urandom_range(1, 8 * 65536));
			load_sphere($signed($urandom_range(0, 200 * 65536)) - 100 * 65536,
				$urandom, $signed($urandom_range(0, 2000)) - 1000, $urandom_range(0, 65536),
				r, 62'(r) * 62'(r) + (ph == 2 ? 62'($urandom) : 62'd0),
				ph == 1 ? 16'd0 : 16'($urandom));
			for (int k = 0; k < 100; k++)
				push_random_ray();
			if (ph == 0) begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			wait_drained();
		end

		$display("covered %0d result beats, %0d hits, %0d shadow-only rays offered",
			n_results, n_hits, n_shadow_hits);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
